### rtl/core/canfst_pkg.sv
// ============================================================================
// CAN frame statistics package
// Shared widths, event kind codes, UDS limits, table entry and result types.
// ============================================================================
package canfst_pkg;

    // Number of identifier slots in the statistics table.
    localparam int TABLE_DEPTH = 64;

    // Slot index wide enough to hold TABLE_DEPTH itself (the "no entry" code).
    localparam int IDX_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int KIND_W = 2;
    localparam int TIME_W = 48;
    localparam int ID_W   = 29;
    localparam int LEN_W  = 4;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;

    // Iteration counter of the bit-serial divider.
    localparam int DIV_CNT_W = $clog2(TIME_W);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Event kinds; the unused code is treated as an invalid line.
    localparam logic [KIND_W-1:0] KIND_CLASSIC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FD      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

    // UDS service identifier classes of the first data byte.
    localparam logic [BYTE_W-1:0] UDS_REQ_MAX = 8'h3F;
    localparam logic [BYTE_W-1:0] UDS_POS_MAX = 8'h7E;
    localparam logic [BYTE_W-1:0] UDS_NEG     = 8'h7F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_UPDATE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Input item fields, first field in the highest bits.
    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [LEN_W-1:0]  length_code;
        logic [ID_W-1:0]   frame_id;
        logic [TIME_W-1:0] time_stamp;
    } in_item_t;

    localparam int IN_W       = $bits(in_item_t);
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

    // Result item fields, first field in the highest bits.
    typedef struct packed {
        logic [CNT_W-1:0]  uds_negative;
        logic [CNT_W-1:0]  uds_positive;
        logic [CNT_W-1:0]  uds_requests;
        logic [CNT_W-1:0]  invalid_lines;
        logic [CNT_W-1:0]  fd_frames;
        logic [IDX_W-1:0]  unique_ids;
        logic [CNT_W-1:0]  all_frames;
        logic [TIME_W-1:0] average_period;
        logic [TIME_W-1:0] entry_last_time;
        logic [TIME_W-1:0] entry_first_time;
        logic [CNT_W-1:0]  entry_frames;
        logic [IDX_W-1:0]  entry_index;
    } out_item_t;

    localparam int OUT_W       = $bits(out_item_t);
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // One slot of the identifier table.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  frames;
        logic [TIME_W-1:0] first_time;
        logic [TIME_W-1:0] last_time;
    } table_entry_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/core/can_frame_statistics_table.sv
// ============================================================================
// CAN frame statistics table
// Counts parsed CAN events and keeps per-identifier frame statistics.
// ============================================================================
//
// Usage: parsed CAN events enter on the s_axis channel, one item per event,
// with the event kind on s_axis_tuser. Every item gives exactly one result
// item on the m_axis channel: the table slot touched (or the no-entry code),
// that slot's frame count, first and last timestamps and average period, and
// all running totals after the update.
//
// Flow: an FD frame or an invalid line goes from acceptance straight to the
// result stage. A classic frame walks the table slot by slot (memory read,
// then compare), updates or adds its slot, and, when the slot then holds two
// or more frames, runs the bit-serial divider that forms the average period.
// The block takes one item at a time: s_axis_tready is high only while idle.
//
// Reset clears all counters and the slot fill count; the table memory is not
// cleared since only slots below the fill count are ever read. When the
// receiver stalls, the finished result waits in the output register and the
// block holds in its final state until the register is free.
//
module can_frame_statistics_table
    import canfst_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // time_stamp[47:0], frame_id[76:48], length_code[80:77], first_byte[88:81]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [KIND_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // entry_index[6:0], entry_frames[38:7], entry_first_time[86:39],
    // entry_last_time[134:87], average_period[182:135], all_frames[214:183],
    // unique_ids[221:215], fd_frames[253:222], invalid_lines[285:254],
    // uds_requests[317:286], uds_positive[349:318], uds_negative[381:350]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Control state.
    state_t            state_reg,    state_next;
    logic [IDX_W-1:0]  used_reg,     used_next;
    logic [CNT_W-1:0]  frame_total_reg,    frame_total_next;
    logic [CNT_W-1:0]  fd_total_reg,       fd_total_next;
    logic [CNT_W-1:0]  invalid_total_reg,  invalid_total_next;
    logic [CNT_W-1:0]  request_total_reg,  request_total_next;
    logic [CNT_W-1:0]  positive_total_reg, positive_total_next;
    logic [CNT_W-1:0]  negative_total_reg, negative_total_next;
    logic              m_valid_reg,  m_valid_next;

    // Item payload and working registers.
    logic [TIME_W-1:0] ts_reg,       ts_next;
    logic [ID_W-1:0]   fid_reg,      fid_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic              found_reg,    found_next;
    logic [IDX_W-1:0]  slot_reg,     slot_next;
    table_entry_t      ent_reg,      ent_next;
    logic [CNT_W-1:0]  div_reg,      div_next;
    logic [TIME_W-1:0] quo_reg,      quo_next;
    logic [CNT_W-1:0]  rem_reg,      rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    out_item_t         out_reg,      out_next;

    // Identifier table memory.
    table_entry_t      table_mem [0:TABLE_DEPTH-1];
    table_entry_t      rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    table_entry_t      mem_wdata;

    in_item_t          in_item;
    logic              in_fire;
    logic [IDX_W-1:0]  idx_inc;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    table_entry_t      upd_entry;

    assign in_item       = in_item_t'(s_axis_tdata[IN_W-1:0]);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_reg);

    assign idx_inc = idx_reg + IDX_W'(1);

    // One restoring-division step: shift in the next dividend bit, try a subtract.
    assign trial = {rem_reg, quo_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            used_reg           <= '0;
            frame_total_reg    <= '0;
            fd_total_reg       <= '0;
            invalid_total_reg  <= '0;
            request_total_reg  <= '0;
            positive_total_reg <= '0;
            negative_total_reg <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            used_reg           <= used_next;
            frame_total_reg    <= frame_total_next;
            fd_total_reg       <= fd_total_next;
            invalid_total_reg  <= invalid_total_next;
            request_total_reg  <= request_total_next;
            positive_total_reg <= positive_total_next;
            negative_total_reg <= negative_total_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg      <= ts_next;
        fid_reg     <= fid_next;
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        ent_reg     <= ent_next;
        div_reg     <= div_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_SRCH_RD)
        begin
            rdata_reg <= table_mem[idx_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        used_next           = used_reg;
        frame_total_next    = frame_total_reg;
        fd_total_next       = fd_total_reg;
        invalid_total_next  = invalid_total_reg;
        request_total_next  = request_total_reg;
        positive_total_next = positive_total_reg;
        negative_total_next = negative_total_reg;
        m_valid_next        = m_valid_reg;
        ts_next             = ts_reg;
        fid_next            = fid_reg;
        idx_next            = idx_reg;
        found_next          = found_reg;
        slot_next           = slot_reg;
        ent_next            = ent_reg;
        div_next            = div_reg;
        quo_next            = quo_reg;
        rem_next            = rem_reg;
        div_cnt_next        = div_cnt_reg;
        out_next            = out_reg;
        mem_we              = 1'b0;
        mem_waddr           = idx_reg[ADDR_W-1:0];
        mem_wdata           = rdata_reg;
        upd_entry           = rdata_reg;

        // The downstream side frees the result register on its handshake.
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ts_next   = in_item.time_stamp;
                    fid_next  = in_item.frame_id;
                    idx_next  = '0;
                    found_next = 1'b0;
                    // Default to the no-entry result.
                    slot_next = IDX_W'(TABLE_DEPTH);
                    ent_next  = '0;
                    quo_next  = '0;
                    if (s_axis_tuser == KIND_CLASSIC)
                    begin
                        frame_total_next = sat_inc(frame_total_reg);
                        if (in_item.first_byte <= UDS_REQ_MAX)
                        begin
                            request_total_next = sat_inc(request_total_reg);
                        end
                        else if (in_item.first_byte == UDS_NEG)
                        begin
                            negative_total_next = sat_inc(negative_total_reg);
                        end
                        else if (in_item.first_byte <= UDS_POS_MAX)
                        begin
                            positive_total_next = sat_inc(positive_total_reg);
                        end
                        state_next = (used_reg == '0) ? ST_UPDATE : ST_SRCH_RD;
                    end
                    else if (s_axis_tuser == KIND_FD)
                    begin
                        frame_total_next = sat_inc(frame_total_reg);
                        fd_total_next    = sat_inc(fd_total_reg);
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        invalid_total_next = sat_inc(invalid_total_reg);
                        state_next         = ST_EMIT;
                    end
                end
            end

            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                if (rdata_reg.id == fid_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_UPDATE;
                end
                else if (idx_inc == used_reg)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_UPDATE:
            begin
                state_next = ST_EMIT;
                if (found_reg)
                begin
                    upd_entry.frames    = sat_inc(rdata_reg.frames);
                    upd_entry.last_time = ts_reg;
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg[ADDR_W-1:0];
                    mem_wdata = upd_entry;
                    slot_next = idx_reg;
                    ent_next  = upd_entry;
                    // Average period needs two frames and time that did not run backward.
                    if (upd_entry.frames >= CNT_W'(2) &&
                        upd_entry.last_time >= upd_entry.first_time)
                    begin
                        div_next     = upd_entry.frames - CNT_W'(1);
                        quo_next     = upd_entry.last_time - upd_entry.first_time;
                        rem_next     = '0;
                        div_cnt_next = DIV_CNT_W'(TIME_W - 1);
                        state_next   = ST_DIV;
                    end
                end
                else if (used_reg < IDX_W'(TABLE_DEPTH))
                begin
                    upd_entry.id         = fid_reg;
                    upd_entry.frames     = CNT_W'(1);
                    upd_entry.first_time = ts_reg;
                    upd_entry.last_time  = ts_reg;
                    mem_we    = 1'b1;
                    mem_waddr = used_reg[ADDR_W-1:0];
                    mem_wdata = upd_entry;
                    slot_next = used_reg;
                    ent_next  = upd_entry;
                    used_next = used_reg + IDX_W'(1);
                end
            end

            ST_DIV:
            begin
                if (!diff[CNT_W])
                begin
                    rem_next = diff[CNT_W-1:0];
                    quo_next = {quo_reg[TIME_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[TIME_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_next.entry_index      = slot_reg;
                    out_next.entry_frames     = ent_reg.frames;
                    out_next.entry_first_time = ent_reg.first_time;
                    out_next.entry_last_time  = ent_reg.last_time;
                    out_next.average_period   = quo_reg;
                    out_next.all_frames       = frame_total_reg;
                    out_next.unique_ids       = used_reg;
                    out_next.fd_frames        = fd_total_reg;
                    out_next.invalid_lines    = invalid_total_reg;
                    out_next.uds_requests     = request_total_reg;
                    out_next.uds_positive     = positive_total_reg;
                    out_next.uds_negative     = negative_total_reg;
                    m_valid_next              = 1'b1;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The fill count never passes the table depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= IDX_W'(TABLE_DEPTH))
        else $error("slot fill count exceeds table depth");

    // The table walk only reads filled slots.
    a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_RD) |-> (idx_reg < used_reg))
        else $error("table walk reads an unfilled slot");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_reg != '0))
        else $error("divider started with zero divisor");

    // FD frames and invalid lines go straight to the result stage.
    a_short_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser != KIND_CLASSIC) |=> (state_reg == ST_EMIT))
        else $error("non-classic event did not go straight to result");

endmodule
